FILE: src/so3_pkg.sv
// Shared constants and transaction types for the SO(3) exponential map pipeline.
`default_nettype none
package so3_pkg;

  localparam int unsigned TaylorTerms = 18;
  localparam logic [31:0] HalfPiQ28   = 32'd421657428;
  localparam logic [31:0] OneQ30      = 32'h4000_0000;

  typedef struct packed {
    logic             valid;
    logic             zero;
    logic [2:0]       neg;
    logic [2:0][31:0] mag;
    logic [31:0]      phi;
  } so3_norm_t;

  typedef struct packed {
    logic             valid;
    logic             zero;
    logic [2:0][31:0] axis;
    logic [1:0]       quad;
    logic [30:0]      ang;
  } so3_axis_t;

  typedef struct packed {
    logic             valid;
    logic             zero;
    logic [2:0][31:0] axis;
    logic [31:0]      sn;
    logic [31:0]      cs;
  } so3_trig_t;

  typedef struct packed {
    logic             valid;
    logic             ident;
    logic [8:0][31:0] m;
  } so3_res_t;

endpackage
`default_nettype wire

FILE: src/so3_sqrt.sv
// Squared norm and bit-per-stage integer square root of the rotation vector.
`default_nettype none
module so3_sqrt import so3_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [2:0][31:0] vec_i,
  output so3_norm_t        norm_o
);

  typedef struct packed {
    logic             zero;
    logic [2:0]       neg;
    logic [2:0][31:0] mag;
  } side_t;

  side_t            abs_d;
  side_t            abs_q;
  logic             abs_vld_q;
  side_t            sq_side_q;
  logic [2:0][63:0] sq_q;
  logic             sq_vld_q;

  logic        root_vld_q  [0:32];
  side_t       root_side_q [0:32];
  logic [63:0] rem_q       [0:32];
  logic [31:0] root_q      [0:32];

  always_comb begin
    abs_d.zero = (vec_i == '0);
    for (int i = 0; i < 3; i++) begin
      abs_d.neg[i] = vec_i[i][31];
      abs_d.mag[i] = vec_i[i][31] ? (~vec_i[i] + 32'd1) : vec_i[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      abs_vld_q     <= 1'b0;
      sq_vld_q      <= 1'b0;
      root_vld_q[0] <= 1'b0;
    end else begin
      abs_vld_q     <= in_valid_i;
      sq_vld_q      <= abs_vld_q;
      root_vld_q[0] <= sq_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    abs_q     <= abs_d;
    sq_side_q <= abs_q;
    for (int i = 0; i < 3; i++) begin
      sq_q[i] <= 64'(abs_q.mag[i]) * 64'(abs_q.mag[i]);
    end
    root_side_q[0] <= sq_side_q;
    rem_q[0]       <= sq_q[0] + sq_q[1] + sq_q[2];
    root_q[0]      <= '0;
  end

  for (genvar k = 0; k < 32; k++) begin : g_root
    localparam int B = 31 - k;
    logic [65:0] trial;
    logic        fit;
    logic [63:0] rem_d;
    logic [31:0] root_d;

    always_comb begin
      trial  = (66'(root_q[k]) << (B + 1)) + (66'd1 << (2 * B));
      fit    = (66'(rem_q[k]) >= trial);
      rem_d  = fit ? (rem_q[k] - trial[63:0]) : rem_q[k];
      root_d = fit ? (root_q[k] | (32'd1 << B)) : root_q[k];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        root_vld_q[k+1] <= 1'b0;
      end else begin
        root_vld_q[k+1] <= root_vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      root_side_q[k+1] <= root_side_q[k];
      rem_q[k+1]       <= rem_d;
      root_q[k+1]      <= root_d;
    end
  end

  always_comb begin
    norm_o.valid = root_vld_q[32];
    norm_o.zero  = root_side_q[32].zero;
    norm_o.neg   = root_side_q[32].neg;
    norm_o.mag   = root_side_q[32].mag;
    norm_o.phi   = root_q[32];
  end

endmodule
`default_nettype wire

FILE: src/so3_div.sv
// Unit-axis restoring division and quadrant range reduction of the angle.
`default_nettype none
module so3_div import so3_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  so3_norm_t norm_i,
  output so3_axis_t axis_o
);

  typedef struct packed {
    logic        zero;
    logic [2:0]  neg;
    logic [31:0] phi;
    logic [31:0] rr;
    logic [3:0]  quo;
  } side_t;

  logic             vld_q  [0:31];
  side_t            side_q [0:31];
  logic [2:0][31:0] rem_q  [0:31];
  logic [2:0][30:0] low_q  [0:31];
  logic [2:0][30:0] quot_q [0:31];

  logic [2:0][61:0] num;
  so3_axis_t        out_d;
  so3_axis_t        out_q;
  logic             out_vld_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i] = {norm_i.mag[i], 30'd0} + 62'(norm_i.phi >> 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0]  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      vld_q[0]  <= norm_i.valid;
      out_vld_q <= vld_q[31];
    end
  end

  always_ff @(posedge clk_i) begin
    side_q[0].zero <= norm_i.zero;
    side_q[0].neg  <= norm_i.neg;
    side_q[0].phi  <= norm_i.phi;
    side_q[0].rr   <= norm_i.phi;
    side_q[0].quo  <= '0;
    for (int i = 0; i < 3; i++) begin
      rem_q[0][i]  <= 32'(num[i][61:31]);
      low_q[0][i]  <= num[i][30:0];
      quot_q[0][i] <= '0;
    end
    out_q <= out_d;
  end

  for (genvar k = 0; k < 31; k++) begin : g_div
    localparam int B         = 30 - k;
    localparam bit DoQuad    = (k < 4);
    localparam int QB        = (k < 4) ? (3 - k) : 0;
    localparam logic [31:0] Lim = HalfPiQ28 << QB;
    logic [2:0][32:0] cand;
    logic [2:0][31:0] rem_d;
    logic [2:0][30:0] quot_d;
    side_t            side_d;

    always_comb begin
      side_d = side_q[k];
      if (DoQuad && (side_q[k].rr >= Lim)) begin
        side_d.rr      = side_q[k].rr - Lim;
        side_d.quo[QB] = 1'b1;
      end
      for (int i = 0; i < 3; i++) begin
        cand[i]   = {rem_q[k][i], low_q[k][i][B]};
        quot_d[i] = quot_q[k][i];
        if (cand[i] >= {1'b0, side_q[k].phi}) begin
          rem_d[i]     = 32'(cand[i] - {1'b0, side_q[k].phi});
          quot_d[i][B] = 1'b1;
        end else begin
          rem_d[i] = cand[i][31:0];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      side_q[k+1] <= side_d;
      rem_q[k+1]  <= rem_d;
      low_q[k+1]  <= low_q[k];
      quot_q[k+1] <= quot_d;
    end
  end

  always_comb begin
    logic [30:0] r;
    out_d       = '0;
    out_d.zero  = side_q[31].zero;
    out_d.quad  = side_q[31].quo[1:0];
    out_d.ang   = {side_q[31].rr[28:0], 2'b00};
    for (int i = 0; i < 3; i++) begin
      r = (quot_q[31][i] > 31'(OneQ30)) ? 31'(OneQ30) : quot_q[31][i];
      out_d.axis[i] = side_q[31].neg[i] ? (32'd0 - 32'(r)) : 32'(r);
    end
  end

  always_comb begin
    axis_o       = out_q;
    axis_o.valid = out_vld_q;
  end

endmodule
`default_nettype wire

FILE: src/so3_sincos.sv
// Pipelined Taylor series for sine and cosine with quadrant unfolding.
`default_nettype none
module so3_sincos import so3_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  so3_axis_t axis_i,
  output so3_trig_t trig_o
);

  typedef struct packed {
    logic               zero;
    logic [2:0][31:0]   axis;
    logic [1:0]         quad;
    logic [30:0]        ang;
    logic [30:0]        term;
    logic signed [33:0] sin_acc;
    logic signed [33:0] cos_acc;
  } tay_t;

  tay_t      st_q  [1:TaylorTerms];
  logic      vld_q [1:TaylorTerms];
  so3_trig_t out_d;
  so3_trig_t out_q;
  logic      out_vld_q;

  function automatic logic signed [31:0] clamp_one(input logic signed [33:0] v);
    if (v > 34'sd1073741824) begin
      return 32'sd1073741824;
    end else if (v < -34'sd1073741824) begin
      return -32'sd1073741824;
    end else begin
      return v[31:0];
    end
  endfunction

  for (genvar n = 1; n <= TaylorTerms; n++) begin : g_term
    localparam int N  = n;
    localparam int Ph = n % 4;
    localparam logic [32:0] Recip = 33'((64'd1 << 32) / N);
    tay_t        in_st;
    logic        in_vld;
    tay_t        a_q;
    logic        a_vld_q;
    logic [61:0] p_q;
    tay_t        b_q;
    logic        b_vld_q;
    logic [61:0] ysum;
    logic [31:0] y_d;
    logic [31:0] y_q;
    logic [64:0] m_q;
    logic [31:0] q0;
    logic [31:0] r;
    logic [31:0] q1;
    tay_t        st_d;

    if (n == 1) begin : g_first
      assign in_vld = axis_i.valid;
      always_comb begin
        in_st.zero    = axis_i.zero;
        in_st.axis    = axis_i.axis;
        in_st.quad    = axis_i.quad;
        in_st.ang     = axis_i.ang;
        in_st.term    = 31'(OneQ30);
        in_st.sin_acc = '0;
        in_st.cos_acc = 34'(OneQ30);
      end
    end else begin : g_next
      assign in_vld = vld_q[n-1];
      assign in_st  = st_q[n-1];
    end

    always_comb begin
      ysum = p_q + (62'(N) << 29);
      y_d  = ysum[61:30];
      q0   = m_q[63:32];
      r    = y_q - q0 * 32'(N);
      q1   = (r >= 32'(N)) ? (q0 + 32'd1) : q0;
      st_d      = b_q;
      st_d.term = q1[30:0];
      case (Ph)
        0:       st_d.cos_acc = b_q.cos_acc + $signed({2'b00, q1});
        1:       st_d.sin_acc = b_q.sin_acc + $signed({2'b00, q1});
        2:       st_d.cos_acc = b_q.cos_acc - $signed({2'b00, q1});
        default: st_d.sin_acc = b_q.sin_acc - $signed({2'b00, q1});
      endcase
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        a_vld_q  <= 1'b0;
        b_vld_q  <= 1'b0;
        vld_q[n] <= 1'b0;
      end else begin
        a_vld_q  <= in_vld;
        b_vld_q  <= a_vld_q;
        vld_q[n] <= b_vld_q;
      end
    end

    always_ff @(posedge clk_i) begin
      a_q     <= in_st;
      p_q     <= 62'(in_st.term) * 62'(in_st.ang);
      b_q     <= a_q;
      y_q     <= y_d;
      m_q     <= 65'(y_d) * 65'(Recip);
      st_q[n] <= st_d;
    end
  end

  always_comb begin
    logic signed [31:0] s;
    logic signed [31:0] c;
    s          = clamp_one(st_q[TaylorTerms].sin_acc);
    c          = clamp_one(st_q[TaylorTerms].cos_acc);
    out_d      = '0;
    out_d.zero = st_q[TaylorTerms].zero;
    out_d.axis = st_q[TaylorTerms].axis;
    case (st_q[TaylorTerms].quad)
      2'd0: begin
        out_d.sn = s;
        out_d.cs = c;
      end
      2'd1: begin
        out_d.sn = c;
        out_d.cs = -s;
      end
      2'd2: begin
        out_d.sn = -s;
        out_d.cs = -c;
      end
      default: begin
        out_d.sn = -c;
        out_d.cs = s;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= vld_q[TaylorTerms];
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_comb begin
    trig_o       = out_q;
    trig_o.valid = out_vld_q;
  end

endmodule
`default_nettype wire

FILE: src/so3_mat.sv
// Rodrigues matrix assembly: outer product, scaling, rounding and saturation.
`default_nettype none
module so3_mat import so3_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  so3_trig_t trig_i,
  output so3_res_t  res_o
);

  logic [3:0] vld_q;
  logic [3:0] zero_q;

  logic signed [63:0] pr_q  [0:5];
  logic signed [63:0] sa_q  [0:2];
  logic signed [32:0] omc_q [0:1];
  logic signed [31:0] cs_q  [0:2];
  logic signed [31:0] aa_q  [0:5];
  logic signed [31:0] sap_q [0:1][0:2];
  logic signed [31:0] san_q [0:1][0:2];
  logic signed [64:0] x_q   [0:5];
  logic [8:0][31:0]   m_q;
  logic [8:0][31:0]   m_d;

  logic signed [31:0] ax [0:2];
  logic signed [31:0] sn;

  function automatic logic signed [34:0] rnd30(input logic signed [64:0] w);
    logic signed [64:0] v;
    v = w + 65'sd536870912;
    return v[64:30];
  endfunction

  function automatic logic [31:0] sat32(input logic signed [35:0] e);
    if (e > 36'sd2147483647) begin
      return 32'h7fff_ffff;
    end else if (e < -36'sd2147483648) begin
      return 32'h8000_0000;
    end else begin
      return e[31:0];
    end
  endfunction

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ax[i] = $signed(trig_i.axis[i]);
    end
    sn = $signed(trig_i.sn);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], trig_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    zero_q <= {zero_q[2:0], trig_i.zero};

    pr_q[0]  <= ax[0] * ax[0];
    pr_q[1]  <= ax[0] * ax[1];
    pr_q[2]  <= ax[0] * ax[2];
    pr_q[3]  <= ax[1] * ax[1];
    pr_q[4]  <= ax[1] * ax[2];
    pr_q[5]  <= ax[2] * ax[2];
    for (int k = 0; k < 3; k++) begin
      sa_q[k] <= sn * ax[k];
    end
    omc_q[0] <= 33'sd1073741824 - 33'($signed(trig_i.cs));
    cs_q[0]  <= $signed(trig_i.cs);

    for (int p = 0; p < 6; p++) begin
      aa_q[p] <= 32'(rnd30(65'(pr_q[p])));
    end
    for (int k = 0; k < 3; k++) begin
      sap_q[0][k] <= 32'(rnd30(65'(sa_q[k])));
      san_q[0][k] <= 32'(rnd30(-65'(sa_q[k])));
    end
    omc_q[1] <= omc_q[0];
    cs_q[1]  <= cs_q[0];

    for (int p = 0; p < 6; p++) begin
      x_q[p] <= 65'(omc_q[1]) * 65'(aa_q[p]);
    end
    sap_q[1] <= sap_q[0];
    san_q[1] <= san_q[0];
    cs_q[2]  <= cs_q[1];

    m_q <= m_d;
  end

  always_comb begin
    m_d[0] = sat32(36'(cs_q[2]) + 36'(rnd30(x_q[0])));
    m_d[1] = sat32(36'(rnd30(x_q[1])) + 36'(san_q[1][2]));
    m_d[2] = sat32(36'(rnd30(x_q[2])) + 36'(sap_q[1][1]));
    m_d[3] = sat32(36'(rnd30(x_q[1])) + 36'(sap_q[1][2]));
    m_d[4] = sat32(36'(cs_q[2]) + 36'(rnd30(x_q[3])));
    m_d[5] = sat32(36'(rnd30(x_q[4])) + 36'(san_q[1][0]));
    m_d[6] = sat32(36'(rnd30(x_q[2])) + 36'(san_q[1][1]));
    m_d[7] = sat32(36'(rnd30(x_q[4])) + 36'(sap_q[1][0]));
    m_d[8] = sat32(36'(cs_q[2]) + 36'(rnd30(x_q[5])));
    if (zero_q[2]) begin
      m_d = '0;
      m_d[0] = OneQ30;
      m_d[4] = OneQ30;
      m_d[8] = OneQ30;
    end
  end

  always_comb begin
    res_o.valid = vld_q[3];
    res_o.ident = zero_q[3];
    res_o.m     = m_q;
  end

endmodule
`default_nettype wire

FILE: src/so3_exponential_map.sv
// Top level of the SO(3) exponential map: rotation vector in, rotation matrix out.
// The result strobe done_o rises once for each transaction taken.
// Throughput: one transaction per cycle; busy is never raised and the receiver cannot stall.
// The pipeline holds the 32-stage square root, 31-stage divider and 54-stage series.
// Reset clears every valid bit at once; data registers are not reset.
`default_nettype none
module so3_exponential_map import so3_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] rot_vec_x_i,
  input  logic [31:0] rot_vec_y_i,
  input  logic [31:0] rot_vec_z_i,
  output logic        done_o,
  output logic [31:0] m00_o,
  output logic [31:0] m01_o,
  output logic [31:0] m02_o,
  output logic [31:0] m10_o,
  output logic [31:0] m11_o,
  output logic [31:0] m12_o,
  output logic [31:0] m20_o,
  output logic [31:0] m21_o,
  output logic [31:0] m22_o,
  output logic        is_identity_o
);

  logic [2:0][31:0] vec;
  so3_norm_t        norm;
  so3_axis_t        axis;
  so3_trig_t        trig;
  so3_res_t         res;

  assign busy = 1'b0;
  assign vec  = {rot_vec_z_i, rot_vec_y_i, rot_vec_x_i};

  so3_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (start & ~busy),
    .vec_i      (vec),
    .norm_o     (norm)
  );

  so3_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .norm_i (norm),
    .axis_o (axis)
  );

  so3_sincos u_sincos (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .axis_i (axis),
    .trig_o (trig)
  );

  so3_mat u_mat (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .trig_i (trig),
    .res_o  (res)
  );

  assign done_o        = res.valid;
  assign is_identity_o = res.ident;
  assign m00_o         = res.m[0];
  assign m01_o         = res.m[1];
  assign m02_o         = res.m[2];
  assign m10_o         = res.m[3];
  assign m11_o         = res.m[4];
  assign m12_o         = res.m[5];
  assign m20_o         = res.m[6];
  assign m21_o         = res.m[7];
  assign m22_o         = res.m[8];

endmodule
`default_nettype wire

FILE: tb/tb_so3_exponential_map.sv
// Self-checking testbench for the SO(3) exponential map against a bit-exact fixed-point predictor.
`timescale 1ns / 1ps
module tb_so3_exponential_map;

  typedef struct {
    logic [31:0] m [9];
    logic        ident;
  } rot_mat_t;

  function automatic logic signed [63:0] round_shift(logic signed [63:0] w, int k);
    logic signed [63:0] v;
    v = w + (64'sd1 <<< (k - 1));
    return v >>> k;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] s);
    logic [63:0] res, bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > s) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (s >= res + bit_w) begin
        s = s - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [63:0] clip(logic signed [63:0] v, logic signed [63:0] lo,
                                               logic signed [63:0] hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic rot_mat_t rodrigues(logic [31:0] vx, logic [31:0] vy, logic [31:0] vz);
    rot_mat_t r;
    logic signed [63:0] v [3];
    logic signed [63:0] ax [3];
    logic signed [63:0] h [9];
    logic [63:0] mg [3];
    logic [63:0] s2, phi, q, t, term, rq;
    logic signed [63:0] sacc, cacc, sn, cs, omc, aa, e;
    logic signed [63:0] one;
    one = 64'sd1 << 30;
    v[0] = $signed(vx); v[1] = $signed(vy); v[2] = $signed(vz);
    s2 = 0;
    for (int i = 0; i < 3; i++) begin
      mg[i] = v[i] < 0 ? -v[i] : v[i];
      s2 = s2 + mg[i] * mg[i];
    end
    r.ident = 0;
    if (s2 == 0) begin
      for (int i = 0; i < 9; i++) r.m[i] = (i % 4 == 0) ? 32'h4000_0000 : 32'h0;
      r.ident = 1;
      return r;
    end
    phi = int_sqrt(s2);
    for (int i = 0; i < 3; i++) begin
      rq = ((mg[i] << 30) + (phi >> 1)) / phi;
      if (rq > one) rq = one;
      ax[i] = v[i] < 0 ? -$signed(rq) : $signed(rq);
    end
    q = phi / so3_pkg::HalfPiQ28;
    t = (phi - q * so3_pkg::HalfPiQ28) << 2;
    sacc = 0;
    cacc = one;
    term = one;
    for (int n = 1; n <= so3_pkg::TaylorTerms; n++) begin
      term = round_shift($signed((term * t) / n), 30);
      case (n % 4)
        0: cacc = cacc + $signed(term);
        1: sacc = sacc + $signed(term);
        2: cacc = cacc - $signed(term);
        default: sacc = sacc - $signed(term);
      endcase
    end
    sacc = clip(sacc, -one, one);
    cacc = clip(cacc, -one, one);
    case (q[1:0])
      2'd0: begin sn = sacc; cs = cacc; end
      2'd1: begin sn = cacc; cs = -sacc; end
      2'd2: begin sn = -sacc; cs = -cacc; end
      default: begin sn = -cacc; cs = sacc; end
    endcase
    h[0] = 0;      h[1] = -ax[2]; h[2] = ax[1];
    h[3] = ax[2];  h[4] = 0;      h[5] = -ax[0];
    h[6] = -ax[1]; h[7] = ax[0];  h[8] = 0;
    omc = one - cs;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        aa = round_shift(ax[i] * ax[j], 30);
        e = (i == j) ? cs : 0;
        e = e + round_shift(omc * aa, 30);
        e = e + round_shift(sn * h[i * 3 + j], 30);
        e = clip(e, -64'sd2147483648, 64'sd2147483647);
        r.m[i * 3 + j] = e[31:0];
      end
    end
    return r;
  endfunction

  class matrix_scoreboard;
    rot_mat_t pending[$];
    int errors;
    int checked;
    int identities;

    function void note_vector(logic [31:0] vx, logic [31:0] vy, logic [31:0] vz);
      pending.push_back(rodrigues(vx, vy, vz));
    endfunction

    function void check_matrix(rot_mat_t got);
      rot_mat_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected matrix, expected none, actual m00=%h", $time, got.m[0]);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (want.ident) identities++;
      for (int i = 0; i < 9; i++) begin
        if (got.m[i] !== want.m[i]) begin
          $display("%0t: m%0d%0d expected %h actual %h", $time, i / 3, i % 3,
                   want.m[i], got.m[i]);
          errors++;
        end
      end
      if (got.ident !== want.ident) begin
        $display("%0t: is_identity expected %b actual %b", $time, want.ident, got.ident);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic start = 0;
  logic busy;
  logic [31:0] rot_vec_x_i = 0, rot_vec_y_i = 0, rot_vec_z_i = 0;
  logic done_o, is_identity_o;
  logic [31:0] m00_o, m01_o, m02_o, m10_o, m11_o, m12_o, m20_o, m21_o, m22_o;

  matrix_scoreboard sb = new();
  int burst_left = 0;

  always #10 clk_i = ~clk_i;

  so3_exponential_map dut (.*);

  always @(posedge clk_i) begin
    rot_mat_t got;
    if (rst_ni) begin
      if (start && !busy) sb.note_vector(rot_vec_x_i, rot_vec_y_i, rot_vec_z_i);
      if (done_o) begin
        got.m = '{m00_o, m01_o, m02_o, m10_o, m11_o, m12_o, m20_o, m21_o, m22_o};
        got.ident = is_identity_o;
        sb.check_matrix(got);
      end
    end
  end

  task automatic send_vector(logic [31:0] vx, logic [31:0] vy, logic [31:0] vz);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        start <= 0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 30);
    end
    start <= 1;
    rot_vec_x_i <= vx;
    rot_vec_y_i <= vy;
    rot_vec_z_i <= vz;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    burst_left--;
  endtask

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 15) - 8;
      2: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom())};
      3: return 32'h8000_0000;
      4: return 0;
      default: return {{4{$urandom_range(0, 1) == 1}}, 28'($urandom())};
    endcase
  endfunction

  task automatic drain();
    start <= 0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  initial begin
    logic [31:0] edge_vals [8];
    edge_vals = '{32'h0, 32'h1, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                  32'h1000_0000, 32'd421657428, 32'hf000_0000};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    send_vector(0, 0, 0);
    for (int i = 1; i < 8; i++) send_vector(edge_vals[i], 0, 0);
    send_vector(0, 32'h1000_0000, 0);
    send_vector(0, 0, 32'hf000_0000);
    send_vector(1, 1, 1);
    send_vector(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_vector(32'h8000_0000, 32'h7fff_ffff, 1);
    send_vector(32'd843314856, 0, 0);
    send_vector(32'd1264972284, 0, 0);
    send_vector(0, 0, 0);
    drain();
    for (int i = 0; i < 500; i++) begin
      send_vector(rand_comp(), rand_comp(), rand_comp());
      if (i == 250) drain();
    end
    drain();
    $display("Checked %0d matrices, %0d of them identity, over edge and random vectors.",
             sb.checked, sb.identities);
    if (sb.errors == 0) $display("tb_so3_exponential_map: done, clean");
    else $display("tb_so3_exponential_map: done, errors");
    $finish;
  end

  initial begin
    #2ms;
    $display("tb_so3_exponential_map: done, errors");
    $finish;
  end

endmodule
